/* rtl/assert_macros.svh */
// assertion macros shared by the rtl of the letter histogram block
// no dependencies; files that check their own logic include this header
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold on every clock edge outside reset
`define AST_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// antecedent in one cycle implies consequent in the next
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_HOLDS(lbl, clk, rst_n, prop)
`define AST_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/lhmm_pkg.sv */
// types and constants of the letter histogram block
// no dependencies; used by every module of the block
package lhmm_pkg;

    localparam int unsigned NUM_LETTERS = 26;
    localparam logic [7:0]  CODE_A      = 8'd97;
    localparam logic [4:0]  LAST_INDEX  = 5'd25;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } t_state;

    // controls of the count bank
    typedef struct packed {
        logic inc;
        logic clr;
    } t_cnt_ctrl;

    // controls of the scan unit
    typedef struct packed {
        logic step;
        logic first;
    } t_scan_ctrl;

    // one result item
    typedef struct packed {
        logic       found;
        logic [4:0] most_letter;
        logic [9:0] most_count;
        logic [4:0] least_letter;
        logic [9:0] least_count;
    } t_result;

endpackage

/* rtl/lhmm_counts.sv */
// bank of 26 saturating letter counters with one shared access port
// depends on lhmm_pkg
module lhmm_counts #(
    parameter int CNT_W     = 10,
    parameter int MAX_COUNT = 1023
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lhmm_pkg::t_cnt_ctrl    i_ctrl,
    input  logic [4:0]             i_addr,
    output logic [CNT_W-1:0]       o_count
);

    logic [CNT_W-1:0] r_cnt [lhmm_pkg::NUM_LETTERS];
    logic [CNT_W-1:0] w_cur;
    logic             w_below;

    // single read port shared by counting and scanning
    assign w_cur   = r_cnt[i_addr];
    assign w_below = (w_cur < CNT_W'(MAX_COUNT));
    assign o_count = w_cur;

    // increment with saturation, or clear the entry just scanned
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < lhmm_pkg::NUM_LETTERS; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (i_ctrl.clr) begin
            r_cnt[i_addr] <= '0;
        end else if (i_ctrl.inc && w_below) begin
            r_cnt[i_addr] <= w_cur + CNT_W'(1);
        end
    end

endmodule

/* rtl/lhmm_scan.sv */
// shared compare unit that folds one count a cycle into most/least while step is high
// depends on lhmm_pkg
module lhmm_scan #(
    parameter int CNT_W = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lhmm_pkg::t_scan_ctrl  i_ctrl,
    input  logic [4:0]            i_idx,
    input  logic [CNT_W-1:0]      i_count,
    output lhmm_pkg::t_result     o_result
);

    logic             r_any,       n_any;
    logic [4:0]       r_most_idx,  n_most_idx;
    logic [CNT_W-1:0] r_most_cnt,  n_most_cnt;
    logic [4:0]       r_least_idx, n_least_idx;
    logic [CNT_W-1:0] r_least_cnt, n_least_cnt;

    // fold step: first entry starts from zero, strict compares keep lowest on ties
    always_comb begin
        n_any       = i_ctrl.first ? 1'b0 : r_any;
        n_most_idx  = i_ctrl.first ? 5'd0 : r_most_idx;
        n_most_cnt  = i_ctrl.first ? '0   : r_most_cnt;
        n_least_idx = i_ctrl.first ? 5'd0 : r_least_idx;
        n_least_cnt = i_ctrl.first ? '0   : r_least_cnt;
        if (i_count != '0) begin
            if (!n_any) begin
                n_any       = 1'b1;
                n_most_idx  = i_idx;
                n_most_cnt  = i_count;
                n_least_idx = i_idx;
                n_least_cnt = i_count;
            end else begin
                if (i_count > n_most_cnt) begin
                    n_most_idx = i_idx;
                    n_most_cnt = i_count;
                end
                if (i_count < n_least_cnt) begin
                    n_least_idx = i_idx;
                    n_least_cnt = i_count;
                end
            end
        end
    end

    // control flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any <= 1'b0;
        end else if (i_ctrl.step) begin
            r_any <= n_any;
        end
    end

    // running extremes
    always_ff @(posedge i_clk) begin
        if (i_ctrl.step) begin
            r_most_idx  <= n_most_idx;
            r_most_cnt  <= n_most_cnt;
            r_least_idx <= n_least_idx;
            r_least_cnt <= n_least_cnt;
        end
    end

    assign o_result.found        = r_any;
    assign o_result.most_letter  = r_most_idx;
    assign o_result.most_count   = 10'(r_most_cnt);
    assign o_result.least_letter = r_least_idx;
    assign o_result.least_count  = 10'(r_least_cnt);

endmodule

/* rtl/letter_histogram_min_max_core.sv */
// channel   dir  signals                         item contents
// s_axis    in   tvalid tready tdata[7:0] tlast  one byte of a string, tlast on its final byte
// m_axis    out  tvalid tready tdata[31:0] tuser one result per string
//
// each letter byte, also the last, is counted in its accept cycle: one byte a cycle when ready
// the last byte starts a scan of the 26 counts through one shared compare unit, one
// count a cycle, each entry cleared as it is read; input is not ready during the scan
// and the hold state after it, longer while the previous result waits on the output register
// reset is synchronous, active low, and clears all counts at once
// depends on lhmm_pkg, lhmm_counts, lhmm_scan and assert_macros.svh
`include "assert_macros.svh"
module letter_histogram_min_max_core #(
    parameter int MAX_COUNT = 1023
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [4:0] most_letter, [14:5] most_count,
                                          // [19:15] least_letter, [29:20] least_count,
                                          // [31:30] zero
    output logic        o_m_axis_tuser    // [0] found
);

    localparam int CNT_W = $clog2(MAX_COUNT + 1);

    lhmm_pkg::t_state     r_state, n_state;
    logic [4:0]           r_idx;
    logic                 r_out_valid;
    lhmm_pkg::t_result    r_out;
    lhmm_pkg::t_cnt_ctrl  w_cnt_ctrl;
    lhmm_pkg::t_scan_ctrl w_scan_ctrl;
    lhmm_pkg::t_result    w_result;
    logic                 w_acc;
    logic                 w_letter;
    logic [7:0]           w_offset;
    logic [4:0]           w_addr;
    logic [CNT_W-1:0]     w_count;
    logic                 w_out_free;
    logic                 w_load;

    // byte decode
    assign w_offset   = i_s_axis_tdata - lhmm_pkg::CODE_A;
    assign w_letter   = (i_s_axis_tdata >= lhmm_pkg::CODE_A) &&
                        (w_offset <= 8'(lhmm_pkg::LAST_INDEX));
    assign w_acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lhmm_pkg::ST_IDLE: begin
                if (w_acc && i_s_axis_tlast) n_state = lhmm_pkg::ST_SCAN;
            end
            lhmm_pkg::ST_SCAN: begin
                if (r_idx == lhmm_pkg::LAST_INDEX) n_state = lhmm_pkg::ST_HOLD;
            end
            lhmm_pkg::ST_HOLD: begin
                if (w_out_free) n_state = lhmm_pkg::ST_IDLE;
            end
            default: n_state = lhmm_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready   = 1'b0;
        w_cnt_ctrl.inc    = 1'b0;
        w_cnt_ctrl.clr    = 1'b0;
        w_scan_ctrl.step  = 1'b0;
        w_scan_ctrl.first = 1'b0;
        w_load            = 1'b0;
        w_addr            = w_offset[4:0];
        unique case (r_state)
            lhmm_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                w_cnt_ctrl.inc  = i_s_axis_tvalid && w_letter;
            end
            lhmm_pkg::ST_SCAN: begin
                w_cnt_ctrl.clr    = 1'b1;
                w_scan_ctrl.step  = 1'b1;
                w_scan_ctrl.first = (r_idx == 5'd0);
                w_addr            = r_idx;
            end
            lhmm_pkg::ST_HOLD: begin
                w_load = w_out_free;
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    // state and scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lhmm_pkg::ST_IDLE;
            r_idx   <= 5'd0;
        end else begin
            r_state <= n_state;
            if (r_state == lhmm_pkg::ST_SCAN) begin
                r_idx <= r_idx + 5'd1;
            end else begin
                r_idx <= 5'd0;
            end
        end
    end

    lhmm_counts #(
        .CNT_W     (CNT_W),
        .MAX_COUNT (MAX_COUNT)
    ) u_counts (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_cnt_ctrl),
        .i_addr  (w_addr),
        .o_count (w_count)
    );

    lhmm_scan #(
        .CNT_W (CNT_W)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_scan_ctrl),
        .i_idx    (r_idx),
        .i_count  (w_count),
        .o_result (w_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.found;
    assign o_m_axis_tdata  = {2'b00, r_out.least_count, r_out.least_letter,
                              r_out.most_count, r_out.most_letter};

    // checks
    `AST_NEXT(a_last_starts_scan, i_clk, i_rst_n,
              w_acc && i_s_axis_tlast,
              (r_state == lhmm_pkg::ST_SCAN) && (r_idx == 5'd0))
    `AST_NEXT(a_scan_advances, i_clk, i_rst_n,
              (r_state == lhmm_pkg::ST_SCAN) && (r_idx != lhmm_pkg::LAST_INDEX),
              (r_state == lhmm_pkg::ST_SCAN) && (r_idx == 5'($past(r_idx) + 5'd1)))
    `AST_NEXT(a_scan_ends_hold, i_clk, i_rst_n,
              (r_state == lhmm_pkg::ST_SCAN) && (r_idx == lhmm_pkg::LAST_INDEX),
              r_state == lhmm_pkg::ST_HOLD)
    `AST_NEXT(a_hold_delivers, i_clk, i_rst_n,
              (r_state == lhmm_pkg::ST_HOLD) && w_out_free,
              (r_state == lhmm_pkg::ST_IDLE) && o_m_axis_tvalid)

endmodule

/* dv/tb_letter_histogram_min_max_core.sv */
// testbench for letter_histogram_min_max_core: streams strings in, checks one scan result per string
// depends on lhmm_pkg and the rtl of the core; self-checking, no files or arguments
`timescale 1ns / 100ps
module tb_letter_histogram_min_max_core;
    import lhmm_pkg::*;

    localparam int MAX_COUNT    = 1023;
    localparam int RANDOM_BYTES = 800;
    localparam int SETTLE_CYCLES = 64;

    // characters used by the directed strings
    localparam logic [7:0] CH_A        = CODE_A;
    localparam logic [7:0] CH_B        = CODE_A + 8'd1;
    localparam logic [7:0] CH_C        = CODE_A + 8'd2;
    localparam logic [7:0] CH_D        = CODE_A + 8'd3;
    localparam logic [7:0] CH_E        = CODE_A + 8'd4;
    localparam logic [7:0] CH_K        = CODE_A + 8'd10;
    localparam logic [7:0] CH_M        = CODE_A + 8'd12;
    localparam logic [7:0] CH_Q        = CODE_A + 8'd16;
    localparam logic [7:0] CH_Y        = CODE_A + 8'd24;
    localparam logic [7:0] CH_Z        = CODE_A + LAST_INDEX;
    localparam logic [7:0] CH_BACKTICK = CODE_A - 8'd1;
    localparam logic [7:0] CH_LBRACE   = CODE_A + LAST_INDEX + 8'd1;
    localparam logic [7:0] CH_UPPER_A  = 8'd65;
    localparam logic [7:0] CH_BANG     = 8'd33;

    // one directed row: a byte sent reps times, the last mark on the final copy
    typedef struct packed {
        logic [7:0]  code;
        logic        last;
        logic [10:0] reps;
        logic        typed;
        t_result     want;
    } t_stim_row;

    localparam t_result NO_LETTER = '{1'b0, 5'd0, 10'd0, 5'd0, 10'd0};

    localparam int NUM_ROWS = 19;
    localparam t_stim_row DIRECTED_ROWS [NUM_ROWS] = '{
        // empty string right after reset
        '{CH_BANG,     1'b1, 11'd1,    1'b1, NO_LETTER},
        // lowest and highest letter alone
        '{CH_A,        1'b1, 11'd1,    1'b1, '{1'b1, 5'd0, 10'd1, 5'd0, 10'd1}},
        '{CH_Z,        1'b1, 11'd1,    1'b1, '{1'b1, 5'd25, 10'd1, 5'd25, 10'd1}},
        // bytes just outside the letter range
        '{CH_BACKTICK, 1'b0, 11'd1,    1'b0, NO_LETTER},
        '{CH_LBRACE,   1'b1, 11'd1,    1'b1, NO_LETTER},
        '{8'd0,        1'b0, 11'd1,    1'b0, NO_LETTER},
        '{8'd255,      1'b0, 11'd1,    1'b0, NO_LETTER},
        '{CH_UPPER_A,  1'b1, 11'd1,    1'b1, NO_LETTER},
        // tie between two single letters
        '{CH_C,        1'b0, 11'd1,    1'b0, NO_LETTER},
        '{CH_B,        1'b1, 11'd1,    1'b0, NO_LETTER},
        // mixed counts with ties in the middle
        '{CH_Y,        1'b0, 11'd3,    1'b0, NO_LETTER},
        '{CH_D,        1'b0, 11'd2,    1'b0, NO_LETTER},
        '{CH_K,        1'b0, 11'd2,    1'b0, NO_LETTER},
        '{CH_E,        1'b1, 11'd1,    1'b0, NO_LETTER},
        // saturation of one count, then a single other letter
        '{CH_Q,        1'b0, 11'd1030, 1'b0, NO_LETTER},
        '{CH_A,        1'b1, 11'd1,    1'b1, '{1'b1, 5'd16, 10'd1023, 5'd0, 10'd1}},
        // tie for most with the higher letter first
        '{CH_Z,        1'b0, 11'd2,    1'b0, NO_LETTER},
        '{CH_A,        1'b0, 11'd2,    1'b0, NO_LETTER},
        '{CH_M,        1'b1, 11'd1,    1'b0, NO_LETTER}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;   // [7:0] char_code
    logic        i_s_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;   // [4:0] most_letter, [14:5] most_count,
                                   // [19:15] least_letter, [29:20] least_count, [31:30] zero
    logic        o_m_axis_tuser;   // [0] found

    letter_histogram_min_max_core #(
        .MAX_COUNT (MAX_COUNT)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // letter tallies of the string in flight and the scans still owed
    int      letter_tally [NUM_LETTERS];
    t_result pending_scans [$];

    int send_idle_pct;
    int recv_idle_pct;
    int errors;
    int bytes_sent;
    int strings_sent;
    int scans_checked;
    int empty_scans;
    int saturated_scans;

    // clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // count one byte; on the last byte scan the tallies, then clear them
    function automatic bit tally_byte(input logic [7:0] code, input logic last_flag,
                                      output t_result scan);
        int idx;
        int cnt;
        bit any;
        idx  = int'(code) - int'(CODE_A);
        scan = NO_LETTER;
        any  = 1'b0;
        if (idx >= 0 && idx <= int'(LAST_INDEX) && letter_tally[idx] < MAX_COUNT)
            letter_tally[idx]++;
        if (!last_flag)
            return 1'b0;
        for (int k = 0; k < NUM_LETTERS; k++) begin
            cnt = letter_tally[k];
            if (cnt != 0) begin
                if (!any || cnt > int'(scan.most_count)) begin
                    scan.most_letter = 5'(k);
                    scan.most_count  = 10'(cnt);
                end
                if (!any || cnt < int'(scan.least_count)) begin
                    scan.least_letter = 5'(k);
                    scan.least_count  = 10'(cnt);
                end
                any = 1'b1;
            end
            letter_tally[k] = 0;
        end
        scan.found = any;
        return 1'b1;
    endfunction

    // offer one item, wait for it to be taken, then record what it should produce
    task automatic send_byte(input logic [7:0] code, input logic last_flag,
                             input logic typed, input t_result want);
        t_result scan;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= code;
        i_s_axis_tlast  <= last_flag;
        do @(posedge i_clk); while (!o_s_axis_tready);
        bytes_sent++;
        if (tally_byte(code, last_flag, scan)) begin
            pending_scans.push_back(typed ? want : scan);
            strings_sent++;
        end
    endtask

    // output side: random back-pressure and field-by-field check of each result
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_scans.size() == 0) begin
                $error("result item with no string pending");
                errors++;
            end else begin
                want = pending_scans.pop_front();
                scans_checked++;
                if (!want.found) empty_scans++;
                if (want.most_count == 10'(MAX_COUNT)) saturated_scans++;
                if (o_m_axis_tuser !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_m_axis_tuser);
                    errors++;
                end
                if (o_m_axis_tdata[4:0] !== want.most_letter) begin
                    $error("most_letter: expected %0d, got %0d",
                           want.most_letter, o_m_axis_tdata[4:0]);
                    errors++;
                end
                if (o_m_axis_tdata[14:5] !== want.most_count) begin
                    $error("most_count: expected %0d, got %0d",
                           want.most_count, o_m_axis_tdata[14:5]);
                    errors++;
                end
                if (o_m_axis_tdata[19:15] !== want.least_letter) begin
                    $error("least_letter: expected %0d, got %0d",
                           want.least_letter, o_m_axis_tdata[19:15]);
                    errors++;
                end
                if (o_m_axis_tdata[29:20] !== want.least_count) begin
                    $error("least_count: expected %0d, got %0d",
                           want.least_count, o_m_axis_tdata[29:20]);
                    errors++;
                end
                if (o_m_axis_tdata[31:30] !== 2'b00) begin
                    $error("tdata padding: expected 0, got %0d", o_m_axis_tdata[31:30]);
                    errors++;
                end
            end
        end
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // stimulus: directed table, then random strings in three idling phases
    initial begin : stimulus
        int       random_bytes;
        int       str_len;
        int       style;
        int       base;
        int       span;
        logic [7:0] ch;
        errors          = 0;
        bytes_sent      = 0;
        strings_sent    = 0;
        scans_checked   = 0;
        empty_scans     = 0;
        saturated_scans = 0;
        random_bytes    = 0;
        send_idle_pct   = 32;
        recv_idle_pct   = 79;
        foreach (letter_tally[k]) letter_tally[k] = 0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= 8'd0;
        i_s_axis_tlast  <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[r]) begin
            for (int n = 0; n < int'(DIRECTED_ROWS[r].reps); n++)
                send_byte(DIRECTED_ROWS[r].code,
                          DIRECTED_ROWS[r].last && (n == int'(DIRECTED_ROWS[r].reps) - 1),
                          DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
        end

        while (random_bytes < RANDOM_BYTES) begin
            // swap the idling sides after a third, stop idling after two thirds
            if (random_bytes >= 2 * RANDOM_BYTES / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (random_bytes >= RANDOM_BYTES / 3) begin
                send_idle_pct = 79;
                recv_idle_pct = 32;
            end
            // style 0: noise only, 1..3: few letters so ties are common, else any letter
            style   = $urandom_range(9);
            str_len = ($urandom_range(7) == 0) ? $urandom_range(120, 31) : $urandom_range(30, 1);
            base    = $urandom_range(25);
            span    = $urandom_range(2);
            for (int k = 0; k < str_len; k++) begin
                if (style == 0 || $urandom_range(99) < 12)
                    ch = 8'($urandom_range(255));
                else if (style <= 3)
                    ch = CODE_A + 8'((base + $urandom_range(span)) % NUM_LETTERS);
                else
                    ch = CODE_A + 8'($urandom_range(25));
                send_byte(ch, k == str_len - 1, 1'b0, NO_LETTER);
                random_bytes++;
            end
        end
        i_s_axis_tvalid <= 1'b0;

        // drain the remaining results, then give the block time to misbehave
        while (pending_scans.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("sent %0d bytes in %0d strings; checked %0d results", bytes_sent,
                 strings_sent, scans_checked);
        $display("of those, %0d had no letter and %0d a saturated count", empty_scans,
                 saturated_scans);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
